/* rtl/path_pixel_window_filter_unit_assert.svh */
// Assertion macros used by the path pixel window filter checker.
`ifndef PATH_PIXEL_WINDOW_FILTER_UNIT_ASSERT_SVH
`define PATH_PIXEL_WINDOW_FILTER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define PPWF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define PPWF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ppwf_pkg.sv */
// Shared constants of the path pixel window filter.
package ppwf_pkg;

  // Default coordinate width.
  localparam int COORD_BITS_DEF = 16;

  // Most results one input transaction can cause, and the result queue depth.
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_LINE  = 1'b1;

endpackage

/* rtl/path_pixel_window_filter_unit.sv */
// Path pixel window filter: thins and repairs a stream of path pixels.
//
// The slave channel (in_*) takes one proposed pixel per transaction: tdata holds
// the column and the row, tuser the path break flag. The master channel (out_*)
// gives draw requests: tdata holds start column, start row, end column and end
// row, tuser the kind (pixel or line), and tlast marks the final result caused
// by one input transaction. An input transaction causes zero to three results.
// A transaction is held in an input register until the queue can take its
// results, which are then written into a four-entry result queue; the head of
// the queue drives the master channel directly from the queue registers.
// One input transaction is accepted per cycle as long as the queue, after this
// cycle's read, holds at most one result; with one result per input the block
// sustains one transaction per cycle, and the output port at one result per
// cycle is what limits items that cause more. When the receiver stalls, the
// queue fills and in_tready falls; nothing is lost. Synchronous reset empties
// the queue and the input register and marks all window points invalid.
module path_pixel_window_filter_unit
  import ppwf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // px, py (low bits first), zero padding
  input  logic             in_tuser,   // path_break
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // x_start, y_start, x_end, y_end, padding
  output logic             out_tuser,  // kind
  output logic             out_tlast   // last
);

  localparam int CB    = COORD_BITS;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);
  localparam int RIX_W = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic                 kind;
    logic signed [CB-1:0] xs;
    logic signed [CB-1:0] ys;
    logic signed [CB-1:0] xe;
    logic signed [CB-1:0] ye;
    logic                 last;
  } res_t;

  function automatic res_t mk_res(input logic k, input logic signed [CB-1:0] xs,
                                  input logic signed [CB-1:0] ys,
                                  input logic signed [CB-1:0] xe,
                                  input logic signed [CB-1:0] ye);
    res_t r;
    r.kind = k;
    r.xs   = xs;
    r.ys   = ys;
    r.xe   = xe;
    r.ye   = ye;
    r.last = 1'b0;
    return r;
  endfunction

  // Input register.
  logic                 inv_r;
  logic signed [CB-1:0] px_r;
  logic signed [CB-1:0] py_r;
  logic                 brk_r;

  // Window of three points, entry 0 the newest.
  logic signed [CB-1:0] wx_r   [3];
  logic signed [CB-1:0] wy_r   [3];
  logic [2:0]           wv_r;
  logic signed [CB-1:0] wx_nxt [3];
  logic signed [CB-1:0] wy_nxt [3];
  logic [2:0]           wv_nxt;

  // Result queue, entry 0 at the head.
  res_t             q_r   [QUEUE_DEPTH];
  res_t             q_nxt [QUEUE_DEPTH];
  res_t             q_sh  [QUEUE_DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] base;
  logic             pop;
  logic             push_ok;
  logic             fire;

  // Results of the transaction in the input register.
  res_t             res [MAX_RESULTS];
  logic [RES_W-1:0] res_n;

  // Distances and midpoint between the new point and the newest window point.
  logic signed [CB:0] ddx;
  logic signed [CB:0] ddy;
  logic [CB:0]        dx;
  logic [CB:0]        dy;
  logic signed [CB:0] sx;
  logic signed [CB:0] sy;
  logic signed [CB:0] sx_adj;
  logic signed [CB:0] sy_adj;
  logic signed [CB-1:0] midx;
  logic signed [CB-1:0] midy;
  logic               dup;
  logic               corner;
  logic               near1;
  logic               near2;

  // Handshake and queue occupancy.
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign base       = cnt_r - {{(CNT_W-1){1'b0}}, pop};
  assign push_ok    = (base <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
  assign fire       = inv_r && push_ok;
  assign in_tready  = !inv_r || push_ok;

  // Input register: refilled whenever its transaction moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_tready) begin
      inv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      px_r  <= in_tdata[CB-1:0];
      py_r  <= in_tdata[2*CB-1:CB];
      brk_r <= in_tuser;
    end
  end

  // Geometry of the new point against the newest window point.
  assign ddx    = {px_r[CB-1], px_r} - {wx_r[0][CB-1], wx_r[0]};
  assign ddy    = {py_r[CB-1], py_r} - {wy_r[0][CB-1], wy_r[0]};
  assign dx     = ddx[CB] ? $unsigned(-ddx) : $unsigned(ddx);
  assign dy     = ddy[CB] ? $unsigned(-ddy) : $unsigned(ddy);
  assign near1  = (dx <= (CB+1)'(1)) && (dy <= (CB+1)'(1));
  assign near2  = (dx <= (CB+1)'(2)) && (dy <= (CB+1)'(2));
  assign sx     = {px_r[CB-1], px_r} + {wx_r[0][CB-1], wx_r[0]};
  assign sy     = {py_r[CB-1], py_r} + {wy_r[0][CB-1], wy_r[0]};
  // Halving truncated toward zero: round a negative odd sum up first.
  assign sx_adj = sx + {{CB{1'b0}}, sx[CB]};
  assign sy_adj = sy + {{CB{1'b0}}, sy[CB]};
  assign midx   = sx_adj[CB:1];
  assign midy   = sy_adj[CB:1];
  assign dup    = wv_r[0] && (wx_r[0] == px_r) && (wy_r[0] == py_r);
  assign corner = wv_r[1] &&
                  (((py_r == wy_r[0]) && (dx == (CB+1)'(1)) && (wx_r[0] == wx_r[1])) ||
                   ((px_r == wx_r[0]) && (dy == (CB+1)'(1)) && (wy_r[0] == wy_r[1])));

  // Window update and result list for one transaction.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wx_nxt[i] = wx_r[i];
      wy_nxt[i] = wy_r[i];
    end
    wv_nxt = wv_r;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    res_n = '0;

    if (fire) begin
      if (brk_r) begin
        // Path break: flush the valid points, oldest first.
        for (int i = 2; i >= 0; i--) begin
          if (wv_r[i]) begin
            res[res_n[RIX_W-1:0]] = mk_res(KIND_PIXEL, wx_r[i], wy_r[i], wx_r[i], wy_r[i]);
            res_n = res_n + RES_W'(1);
          end
        end
        wv_nxt = '0;
      end else if (!dup) begin
        // The oldest point leaves the window.
        if (wv_r[2]) begin
          res[res_n[RIX_W-1:0]] = mk_res(KIND_PIXEL, wx_r[2], wy_r[2], wx_r[2], wy_r[2]);
          res_n = res_n + RES_W'(1);
        end
        wx_nxt[2] = wx_r[1];
        wy_nxt[2] = wy_r[1];
        wx_nxt[1] = wx_r[0];
        wy_nxt[1] = wy_r[0];
        wx_nxt[0] = px_r;
        wy_nxt[0] = py_r;
        wv_nxt    = {wv_r[1], wv_r[0], 1'b1};

        if (wv_r[0]) begin
          if (corner) begin
            // Drop the corner point; the older point takes its place.
            wx_nxt[1] = wx_r[1];
            wy_nxt[1] = wy_r[1];
            wv_nxt[2] = 1'b0;
          end else if (near1) begin
            // Connected: nothing more to do.
          end else if (near2) begin
            // Gap of two: insert the midpoint.
            if (wv_r[1]) begin
              res[res_n[RIX_W-1:0]] = mk_res(KIND_PIXEL, wx_r[1], wy_r[1], wx_r[1], wy_r[1]);
              res_n = res_n + RES_W'(1);
            end
            wx_nxt[2] = wx_r[0];
            wy_nxt[2] = wy_r[0];
            wv_nxt[2] = 1'b1;
            wx_nxt[1] = midx;
            wy_nxt[1] = midy;
          end else begin
            // Large gap: request a line and keep only the newest point.
            if (wv_r[1]) begin
              res[res_n[RIX_W-1:0]] = mk_res(KIND_PIXEL, wx_r[1], wy_r[1], wx_r[1], wy_r[1]);
              res_n = res_n + RES_W'(1);
            end
            res[res_n[RIX_W-1:0]] = mk_res(KIND_LINE, wx_r[0], wy_r[0], px_r, py_r);
            res_n = res_n + RES_W'(1);
            wv_nxt[2:1] = 2'b00;
          end
        end
      end
    end

    // Mark the final result of this transaction.
    if (res_n != '0) begin
      res[RIX_W'(res_n - RES_W'(1))].last = 1'b1;
    end
  end

  // Window registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
    end else begin
      wv_r <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      wx_r[i] <= wx_nxt[i];
      wy_r[i] <= wy_nxt[i];
    end
  end

  // Result queue: shift out at the head, append behind the kept entries.
  always_comb begin
    logic [CNT_W-1:0] off;
    for (int s = 0; s < QUEUE_DEPTH - 1; s++) begin
      q_sh[s] = pop ? q_r[s+1] : q_r[s];
    end
    q_sh[QUEUE_DEPTH-1] = q_r[QUEUE_DEPTH-1];
    for (int s = 0; s < QUEUE_DEPTH; s++) begin
      off = CNT_W'(s) - base;
      if (CNT_W'(s) < base) begin
        q_nxt[s] = q_sh[s];
      end else if (off < CNT_W'(res_n)) begin
        q_nxt[s] = res[off[RIX_W-1:0]];
      end else begin
        q_nxt[s] = q_sh[s];
      end
    end
    cnt_nxt = base + CNT_W'(res_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QUEUE_DEPTH; s++) begin
      q_r[s] <= q_nxt[s];
    end
  end

  // Master channel driven from the head of the queue.
  assign out_tdata = OUT_W'({q_r[0].ye, q_r[0].xe, q_r[0].ys, q_r[0].xs});
  assign out_tuser = q_r[0].kind;
  assign out_tlast = q_r[0].last;

endmodule

/* rtl/ppwf_checker.sv */
// Port-level checker for the path pixel window filter, bound to the top level.
`include "path_pixel_window_filter_unit_assert.svh"

module ppwf_checker
  import ppwf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int OUT_W = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser,
  input logic             out_tlast
);

  localparam int CB = COORD_BITS;

  logic [CB-1:0] xs;
  logic [CB-1:0] ys;
  logic [CB-1:0] xe;
  logic [CB-1:0] ye;

  assign xs = out_tdata[CB-1:0];
  assign ys = out_tdata[2*CB-1:CB];
  assign xe = out_tdata[3*CB-1:2*CB];
  assign ye = out_tdata[4*CB-1:3*CB];

  // A stalled result transaction keeps its contents.
  `PPWF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")

  // A pixel request starts and ends at the same point.
  `PPWF_ASSERT(a_pixel_point, out_tvalid && (out_tuser == KIND_PIXEL) |-> (xs == xe) && (ys == ye), "pixel request with distinct end point")

  // A line request is always the final result of its input transaction and has nonzero length.
  `PPWF_ASSERT(a_line_last, out_tvalid && (out_tuser == KIND_LINE) |-> out_tlast && ((xs != xe) || (ys != ye)), "line request not last or of zero length")

  // Reset empties the result queue.
  `PPWF_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result offered straight after reset")

endmodule

bind path_pixel_window_filter_unit ppwf_checker #(.COORD_BITS(COORD_BITS)) u_ppwf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
